// ===== hw/rtl/ufmr_pkg.sv =====
package ufmr_pkg;

   localparam int IDX_W = 10;
   localparam int CNT_W = 11;
   localparam int COUNT_RESET = 1024;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_UNION = 2'd1;
   localparam logic [1:0] OP_FIND  = 2'd2;

   typedef struct packed {
      logic [IDX_W-1:0] root;
      logic             is_root;
      logic             index_error;
   } result_type;

endpackage

// ===== hw/rtl/union_find_min_root_engine.sv =====
// Channel  Direction  Word fields (tdata / tuser / tlast)
// req      in         tdata[9:0] element_index; tuser[1:0] op; tlast last_in_group
// rsp      out        tdata[9:0] root; tuser[0] is_root, tuser[1] index_error
// csr      in         tdata[10:0] element_count
//
// One item at a time through a parent table read loop (S_FIND_RD, S_FIND_EV): a find or union
// walks to the root and points each node on the path at it, then a union merges; a clear resets
// the first element_count entries. Reset starts a clearing pass of all MAX_ELEMENTS entries, one
// parent entry a cycle, with req_tready low; csr writes are taken at all times.
// A finished result sits in the output register; the engine waits only when that
// register is still full at the end of the next item.
module union_find_min_root_engine import ufmr_pkg::*; #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] element_index
   input  logic [1:0]  req_tuser,   // [1:0] op
   input  logic        req_tlast,   // last_in_group
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] root
   output logic [1:0]  rsp_tuser,   // [0] is_root, [1] index_error
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata    // [10:0] element_count
);

   localparam int AW = $clog2(MAX_ELEMENTS);

   logic             res_valid;
   result_type       res;
   logic             take;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [IDX_W-1:0] mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic [IDX_W-1:0] mem_rdata;
   logic             seq_ready;

   logic             rsp_valid_ff;
   result_type       rsp_ff;

   assign csr_tready = 1'b1;
   assign req_tready = seq_ready;
   assign take = res_valid && (!rsp_valid_ff || rsp_tready);

   ufmr_parent_ram #(
      .DEPTH(MAX_ELEMENTS),
      .AW(AW),
      .DW(IDX_W)
   ) u_ram (
      .clock(clock),
      .we(mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   ufmr_seq #(
      .MAX_ELEMENTS(MAX_ELEMENTS),
      .AW(AW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .req_valid(req_tvalid),
      .req_ready(seq_ready),
      .req_op(req_tuser),
      .req_idx(req_tdata[IDX_W-1:0]),
      .req_last(req_tlast),
      .csr_valid(csr_tvalid),
      .csr_value(csr_tdata[CNT_W-1:0]),
      .take(take),
      .res_valid(res_valid),
      .res(res),
      .mem_we(mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata),
      .mem_raddr(mem_raddr),
      .mem_rdata(mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - IDX_W){1'b0}}, rsp_ff.root};
   assign rsp_tuser  = {rsp_ff.index_error, rsp_ff.is_root};

endmodule

// ===== hw/rtl/ufmr_parent_ram.sv =====
module ufmr_parent_ram #(
   parameter int DEPTH = 1024,
   parameter int AW = 10,
   parameter int DW = 10
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/ufmr_seq.sv =====
module ufmr_seq import ufmr_pkg::*; #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int AW = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [IDX_W-1:0] req_idx,
   input  logic             req_last,
   input  logic             csr_valid,
   input  logic [CNT_W-1:0] csr_value,
   input  logic             take,
   output logic             res_valid,
   output result_type       res,
   output logic             mem_we,
   output logic [AW-1:0]    mem_waddr,
   output logic [IDX_W-1:0] mem_wdata,
   output logic [AW-1:0]    mem_raddr,
   input  logic [IDX_W-1:0] mem_rdata
);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CLEAR, S_FIND_RD, S_FIND_EV,
      S_COMP_RD, S_COMP_EV, S_MERGE, S_DONE
   } state_type;

   localparam logic [CNT_W-1:0] CNT_RESET_VAL =
      (MAX_ELEMENTS < COUNT_RESET) ? CNT_W'(MAX_ELEMENTS) : CNT_W'(COUNT_RESET);
   localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_ELEMENTS - 1);

   function automatic logic [AW-1:0] idx_to_addr(input logic [IDX_W-1:0] v);
      logic [AW+IDX_W-1:0] w;
      w = {{AW{1'b0}}, v};
      return w[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] cnt_to_addr(input logic [CNT_W-1:0] v);
      logic [AW+CNT_W-1:0] w;
      w = {{AW{1'b0}}, v};
      return w[AW-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] addr_to_idx(input logic [AW-1:0] v);
      logic [AW+IDX_W-1:0] w;
      w = {{IDX_W{1'b0}}, v};
      return w[IDX_W-1:0];
   endfunction

   state_type        state_ff;
   logic [1:0]       op_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             last_ff;
   logic [IDX_W-1:0] cur_ff;
   logic [IDX_W-1:0] root_ff;
   logic [AW-1:0]    sweep_ff;
   logic [AW-1:0]    sweep_end_ff;
   logic [IDX_W-1:0] group_root_ff;
   logic             group_open_ff;
   logic [CNT_W-1:0] eff_cnt_ff;
   result_type       res_ff;
   logic [CNT_W-1:0] eff_cnt_in;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   always_comb begin
      if (32'(csr_value) > MAX_ELEMENTS) begin
         eff_cnt_in = CNT_W'(MAX_ELEMENTS);
      end else begin
         eff_cnt_in = csr_value;
      end
   end

   // Memory port control follows the state directly.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = addr_to_idx(sweep_ff);
      mem_raddr = idx_to_addr(cur_ff);
      case (state_ff)
         S_INIT, S_CLEAR: begin
            mem_we = 1'b1;
         end
         S_COMP_EV: begin
            mem_we    = 1'b1;
            mem_waddr = idx_to_addr(cur_ff);
            mem_wdata = root_ff;
         end
         S_MERGE: begin
            if (op_ff == OP_UNION && group_open_ff && root_ff != group_root_ff) begin
               mem_we = 1'b1;
               if (root_ff < group_root_ff) begin
                  mem_waddr = idx_to_addr(group_root_ff);
                  mem_wdata = root_ff;
               end else begin
                  mem_waddr = idx_to_addr(root_ff);
                  mem_wdata = group_root_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         sweep_ff      <= '0;
         sweep_end_ff  <= LAST_ENTRY;
         group_root_ff <= '0;
         group_open_ff <= 1'b0;
         eff_cnt_ff    <= CNT_RESET_VAL;
      end else begin
         case (state_ff)
            S_INIT: begin
               if (sweep_ff == sweep_end_ff) begin
                  state_ff <= S_IDLE;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  op_ff   <= req_op;
                  idx_ff  <= req_idx;
                  last_ff <= req_last;
                  cur_ff  <= req_idx;
                  case (req_op)
                     OP_CLEAR: begin
                        if (!csr_valid) begin
                           group_open_ff <= 1'b0;
                        end
                        group_root_ff <= '0;
                        sweep_ff      <= '0;
                        sweep_end_ff  <= cnt_to_addr(eff_cnt_ff - 1'b1);
                        res_ff        <= '0;
                        state_ff      <= (eff_cnt_ff == '0) ? S_DONE : S_CLEAR;
                     end
                     OP_UNION, OP_FIND: begin
                        if ({1'b0, req_idx} >= eff_cnt_ff) begin
                           res_ff   <= {{IDX_W{1'b0}}, 1'b0, 1'b1};
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_FIND_RD;
                        end
                     end
                     default: begin
                        res_ff   <= '0;
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_CLEAR: begin
               if (sweep_ff == sweep_end_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            S_FIND_RD: begin
               state_ff <= S_FIND_EV;
            end
            S_FIND_EV: begin
               if (mem_rdata == cur_ff) begin
                  root_ff  <= cur_ff;
                  cur_ff   <= idx_ff;
                  state_ff <= S_COMP_RD;
               end else begin
                  cur_ff   <= mem_rdata;
                  state_ff <= S_FIND_RD;
               end
            end
            S_COMP_RD: begin
               // The walk from the item reaches the root: path is compressed.
               state_ff <= (cur_ff == root_ff) ? S_MERGE : S_COMP_EV;
            end
            S_COMP_EV: begin
               cur_ff   <= mem_rdata;
               state_ff <= S_COMP_RD;
            end
            S_MERGE: begin
               if (op_ff == OP_UNION) begin
                  if (!group_open_ff || root_ff < group_root_ff) begin
                     group_root_ff <= root_ff;
                     res_ff        <= {root_ff, (root_ff == idx_ff), 1'b0};
                  end else begin
                     res_ff        <= {group_root_ff, (group_root_ff == idx_ff), 1'b0};
                  end
                  if (!csr_valid) begin
                     group_open_ff <= !last_ff;
                  end
               end else begin
                  res_ff <= {root_ff, (root_ff == idx_ff), 1'b0};
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (csr_valid) begin
            eff_cnt_ff    <= eff_cnt_in;
            group_open_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== hw/rtl/ufmr_checker.sv =====
module ufmr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // The reset clearing pass keeps the request side closed.
   assert property (@(posedge clock) reset |=> !req_tready && !rsp_tvalid)
      else $error("ufmr: ready or response valid right after reset");

   // An accepted word leaves the engine busy, so requests are never taken back to back.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ufmr: request taken on back-to-back cycles");

   // An error word carries no root.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 16'd0 && !rsp_tuser[0])
      else $error("ufmr: error response with root data");

   // Hold a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("ufmr: stalled response changed");

endmodule

bind union_find_min_root_engine ufmr_checker u_ufmr_checker (.*);

// ===== tb/tb_union_find_min_root_engine.sv =====
module tb_union_find_min_root_engine import ufmr_pkg::*; ();

   localparam int          MAX_ELEMENTS  = 1024;
   localparam int          RANDOM_ITEMS  = 1300;
   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          TAIL_CYCLES   = 64;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;

   typedef struct packed {
      logic             is_csr;
      logic [1:0]       op;
      logic [IDX_W-1:0] idx;
      logic             close_grp;
      logic [CNT_W-1:0] csr_val;
      logic             typed;
      result_type       want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [15:0] csr_tdata = '0;

   // shadow of the engine state
   logic [IDX_W-1:0] parent_of [MAX_ELEMENTS];
   logic [IDX_W-1:0] grp_root;
   bit               grp_open;
   logic [CNT_W-1:0] elem_count;

   result_type   root_results_due [$];
   plan_row_type plan [$];

   int  error_count = 0;
   int  results_seen = 0;
   int  cycles = 0;
   int  n_union = 0, n_find = 0, n_clear = 0, n_oob = 0, n_unused = 0, n_csr = 0;
   bit  steady_phase = 0;
   bit  hold_request = 0;

   always #2 clock = ~clock;

   union_find_min_root_engine #(.MAX_ELEMENTS(MAX_ELEMENTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  root_results_due.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic void add_row(plan_row_type row);
      plan.insert(plan.size(), row);
   endfunction

   function automatic result_type next_root_result(logic [1:0] op, logic [IDX_W-1:0] idx,
                                                   logic close_grp);
      result_type       res;
      int unsigned      lim;
      int               steps;
      logic [IDX_W-1:0] r, cur, nxt;
      res = '0;
      lim = (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : elem_count;
      if (op == OP_CLEAR) begin
         for (int i = 0; i < lim; i++) parent_of[i] = IDX_W'(i);
         grp_open = 0;
         grp_root = '0;
      end else if (op == OP_UNION || op == OP_FIND) begin
         if (idx >= lim) begin
            res.index_error = 1'b1;
         end else begin
            r = idx;
            steps = 0;
            while (parent_of[r] != r && steps < MAX_ELEMENTS) begin
               r = parent_of[r];
               steps++;
            end
            // point every node on the path straight at the root
            cur = idx;
            steps = 0;
            while (cur != r && steps < MAX_ELEMENTS) begin
               nxt = parent_of[cur];
               parent_of[cur] = r;
               cur = nxt;
               steps++;
            end
            if (op == OP_UNION) begin
               if (!grp_open) begin
                  grp_root = r;
                  grp_open = 1;
               end else if (r < grp_root) begin
                  parent_of[grp_root] = r;
                  grp_root = r;
               end else if (r > grp_root) begin
                  parent_of[r] = grp_root;
               end
               r = grp_root;
               if (close_grp) grp_open = 0;
            end
            res.root = r;
            res.is_root = (r == idx);
         end
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic flag_mismatch(string what, result_type want, result_type seen);
      error_count++;
      if (error_count <= 10)
         $display("%0d: %s: want root=%0d is_root=%0b err=%0b, %s",
                  cycles, what, want.root, want.is_root, want.index_error,
                  $sformatf("got root=%0d is_root=%0b err=%0b",
                            seen.root, seen.is_root, seen.index_error));
   endtask

   task automatic offer_word(logic [1:0] op, logic [IDX_W-1:0] idx, logic close_grp,
                             bit typed, result_type want);
      int         gap;
      result_type guess;
      int unsigned lim;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, idx};
      req_tuser  <= op;
      req_tlast  <= close_grp;
      do @(posedge clock); while (!req_tready);
      lim = (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : elem_count;
      case (op)
         OP_CLEAR: n_clear++;
         OP_UNION: n_union++;
         OP_FIND:  n_find++;
         default:  n_unused++;
      endcase
      if ((op == OP_UNION || op == OP_FIND) && idx >= lim) n_oob++;
      guess = next_root_result(op, idx, close_grp);
      root_results_due.insert(root_results_due.size(), typed ? want : guess);
   endtask

   // write the count only once the engine has drained
   task automatic write_count(logic [CNT_W-1:0] val);
      req_tvalid <= 1'b0;
      while (root_results_due.size() != 0) @(posedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= {5'd0, val};
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      elem_count = val;
      grp_open = 0;
      n_csr++;
   endtask

   function automatic plan_row_type mk_item(logic [1:0] op, logic [IDX_W-1:0] idx,
                                            logic close_grp, logic typed = 0,
                                            logic [IDX_W-1:0] root = '0, logic isr = 0,
                                            logic err = 0);
      plan_row_type row;
      row = '0;
      row.op = op;
      row.idx = idx;
      row.close_grp = close_grp;
      row.typed = typed;
      row.want.root = root;
      row.want.is_root = isr;
      row.want.index_error = err;
      return row;
   endfunction

   function automatic plan_row_type mk_csr(logic [CNT_W-1:0] val);
      plan_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.csr_val = val;
      return row;
   endfunction

   initial begin : rsp_side
      int         stall_left;
      int         hold_left;
      result_type seen;
      result_type want;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            seen.root = rsp_tdata[IDX_W-1:0];
            seen.is_root = rsp_tuser[0];
            seen.index_error = rsp_tuser[1];
            results_seen++;
            if (root_results_due.size() == 0) begin
               flag_mismatch("word with nothing pending", '0, seen);
            end else begin
               want = root_results_due.pop_front();
               if (seen.root != want.root || seen.is_root != want.is_root ||
                   seen.index_error != want.index_error)
                  flag_mismatch("result mismatch", want, seen);
            end
         end
         if (hold_request) begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   initial begin : req_side
      plan_row_type     row;
      int               sent;
      int               phase_len;
      int               phase_no;
      int unsigned      lim;
      int               r;
      logic [1:0]       op;
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] cnt;

      for (int i = 0; i < MAX_ELEMENTS; i++) parent_of[i] = IDX_W'(i);
      grp_root = '0;
      grp_open = 0;
      elem_count = CNT_W'(COUNT_RESET);

      // after reset every element is its own root
      add_row(mk_item(OP_FIND,   10'd0,    1'b0, 1, 10'd0,    1'b1, 1'b0));
      add_row(mk_item(OP_FIND,   10'd1023, 1'b0, 1, 10'd1023, 1'b1, 1'b0));
      add_row(mk_item(OP_UNUSED, 10'd1023, 1'b1, 1));
      add_row(mk_item(OP_CLEAR,  10'd0,    1'b0, 1));
      add_row(mk_item(OP_UNION,  10'd1023, 1'b0));
      add_row(mk_item(OP_UNION,  10'd512,  1'b0));
      add_row(mk_item(OP_UNION,  10'd5,    1'b0));
      add_row(mk_item(OP_UNION,  10'd700,  1'b1));
      add_row(mk_item(OP_UNION,  10'd9,    1'b1));
      add_row(mk_item(OP_FIND,   10'd1023, 1'b0));
      add_row(mk_item(OP_FIND,   10'd700,  1'b0));
      add_row(mk_item(OP_CLEAR,  10'd1023, 1'b1, 1));
      add_row(mk_item(OP_FIND,   10'd700,  1'b0));
      add_row(mk_csr(11'd0));
      add_row(mk_item(OP_FIND,   10'd0,    1'b0, 1, 10'd0, 1'b0, 1'b1));
      add_row(mk_item(OP_UNION,  10'd1023, 1'b1, 1, 10'd0, 1'b0, 1'b1));
      add_row(mk_csr(11'd2047));
      add_row(mk_item(OP_UNION,  10'd1023, 1'b0));
      add_row(mk_item(OP_UNION,  10'd1,    1'b1));
      add_row(mk_csr(11'd1));
      add_row(mk_item(OP_FIND,   10'd1,    1'b0, 1, 10'd0, 1'b0, 1'b1));
      add_row(mk_item(OP_UNION,  10'd0,    1'b1));
      add_row(mk_csr(11'd16));
      add_row(mk_item(OP_UNION,  10'd3,    1'b0));
      add_row(mk_item(OP_UNION,  10'd20,   1'b1, 1, 10'd0, 1'b0, 1'b1));
      add_row(mk_item(OP_UNION,  10'd15,   1'b1));
      add_row(mk_item(OP_UNION,  10'd8,    1'b0));
      add_row(mk_csr(11'd16));
      add_row(mk_item(OP_UNION,  10'd12,   1'b1));
      add_row(mk_item(OP_CLEAR,  10'd0,    1'b0, 1));
      add_row(mk_item(OP_FIND,   10'd1023, 1'b0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_csr) write_count(row.csr_val);
         else offer_word(row.op, row.idx, row.close_grp, row.typed, row.want);
      end

      sent = 0;
      phase_no = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase_no == 0) begin
            cnt = CNT_W'(COUNT_RESET);
         end else begin
            case ($urandom_range(0, 7))
               0, 1, 2, 3: cnt = CNT_W'($urandom_range(2, 64));
               4:          cnt = CNT_W'($urandom_range(65, 1023));
               5:          cnt = CNT_W'(COUNT_RESET);
               6:          cnt = CNT_W'($urandom_range(1025, 2047));
               default: begin
                  r = $urandom_range(0, 2);
                  cnt = (r == 0) ? 11'd0 : (r == 1) ? 11'd1 : 11'd2047;
               end
            endcase
         end
         write_count(cnt);
         steady_phase = (phase_no == 0) || ($urandom_range(0, 3) == 0);
         lim = (cnt > MAX_ELEMENTS) ? MAX_ELEMENTS : cnt;
         phase_len = (lim < 2) ? 20 : $urandom_range(60, 200);
         for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
            // stall the result side long enough to back up the input
            if (phase_no == 0 && n == 30) hold_request = 1;
            r = $urandom_range(0, 99);
            op = (r < 3) ? OP_CLEAR : (r < 5) ? OP_UNUSED : (r < 35) ? OP_FIND : OP_UNION;
            if (lim > 0 && $urandom_range(0, 9) != 0)
               idx = IDX_W'($urandom_range(0, lim - 1));
            else if (lim < MAX_ELEMENTS)
               idx = IDX_W'($urandom_range(lim, MAX_ELEMENTS - 1));
            else
               idx = IDX_W'($urandom_range(0, MAX_ELEMENTS - 1));
            offer_word(op, idx, ($urandom_range(0, 3) == 0), 0, '0);
            sent++;
         end
         phase_no++;
      end
      steady_phase = 0;
      req_tvalid <= 1'b0;

      while (root_results_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d unions, %0d finds, %0d clears, %0d unused ops, %0d out of range",
               n_union, n_find, n_clear, n_unused, n_oob);
      $display("%0d results checked over %0d count settings, %0d cycles, %0d errors",
               results_seen, n_csr, cycles, error_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
